// File: design/dbort_pkg.sv
// ----------------------------------------------------------------------------
// DRAM bank timing package
// Shared types and constants for the open-row bank timing model.
// ----------------------------------------------------------------------------
package dbort_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_SIZE  = 3'd0,
		REG_BANKS     = 3'd1,
		REG_ACCESS    = 3'd2,
		REG_OPEN      = 3'd3,
		REG_CLOSE     = 3'd4,
		REG_WRITE_REC = 3'd5,
		REG_BYPASS    = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_ROW,
		DIV_BANK,
		DIV_PUSH
	} div_state_t;

	typedef struct packed {
		logic [16:0] row_size;
		logic [4:0]  banks;
		logic [15:0] access_lat;
		logic [15:0] open_lat;
		logic [15:0] close_lat;
		logic [15:0] write_rec;
		logic        bypass;
	} cfg_t;

endpackage

// File: design/dbort_front.sv
// ----------------------------------------------------------------------------
// DRAM bank timing front end
// Accepts an access and splits its address into bank and row with a
// restoring bit-serial divider: address / row_size, then that quotient by
// the bank count. Pushes the classified access into the queue.
// ----------------------------------------------------------------------------
module dbort_front #(
	parameter int ADDR_BITS  = 48,
	parameter int BANK_W     = 4,
	parameter int BANK_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [ADDR_BITS-1:0] address,
	input  logic                 write_access,
	input  logic [47:0]          arrival_time,
	input  dbort_pkg::cfg_t      cfg,
	input  logic                 q_full,
	output logic                 busy,
	output logic                 push,
	output logic [BANK_W-1:0]    push_bank,
	output logic [ADDR_BITS-1:0] push_row,
	output logic                 push_wr,
	output logic [47:0]          push_arr
);
	localparam int CNT_W = $clog2(ADDR_BITS + 1);

	dbort_pkg::div_state_t state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [ADDR_BITS-1:0] quo_q;
	logic [16:0]          rem_q;
	logic [16:0]          dvs_q;
	logic [BANK_W-1:0]    bank_q;
	logic                 wr_q;
	logic [47:0]          arr_q;
	logic [17:0]          trial;
	logic                 ge;
	logic [16:0]          rsize;
	logic [4:0]           nb;

	always_comb begin
		rsize = (cfg.row_size == 17'd0) ? 17'd1 : cfg.row_size;
		nb = cfg.banks;
		if (nb == 5'd0)
			nb = 5'd1;
		if (32'(nb) > 32'(BANK_COUNT))
			nb = 5'(BANK_COUNT);
	end

	assign trial = {rem_q, quo_q[ADDR_BITS-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			dbort_pkg::DIV_IDLE: if (take) state_d = dbort_pkg::DIV_ROW;
			dbort_pkg::DIV_ROW:  if (cnt_q == CNT_W'(1)) state_d = dbort_pkg::DIV_BANK;
			dbort_pkg::DIV_BANK: if (cnt_q == CNT_W'(1)) state_d = dbort_pkg::DIV_PUSH;
			dbort_pkg::DIV_PUSH: if (!q_full) state_d = dbort_pkg::DIV_IDLE;
			default:             state_d = dbort_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != dbort_pkg::DIV_IDLE;
		push = (state_q == dbort_pkg::DIV_PUSH) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dbort_pkg::DIV_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dbort_pkg::DIV_IDLE: begin
				quo_q <= address;
				rem_q <= '0;
				dvs_q <= rsize;
				cnt_q <= CNT_W'(ADDR_BITS);
				wr_q  <= write_access;
				arr_q <= arrival_time;
			end
			dbort_pkg::DIV_ROW, dbort_pkg::DIV_BANK: begin
				quo_q <= {quo_q[ADDR_BITS-2:0], ge};
				if (cnt_q == CNT_W'(1) && state_q == dbort_pkg::DIV_ROW) begin
					rem_q <= '0;
					dvs_q <= 17'(nb);
					cnt_q <= CNT_W'(ADDR_BITS);
				end else begin
					rem_q <= ge ? 17'(trial - {1'b0, dvs_q}) : trial[16:0];
					cnt_q <= cnt_q - CNT_W'(1);
				end
				if (cnt_q == CNT_W'(1) && state_q == dbort_pkg::DIV_BANK)
					bank_q <= BANK_W'(ge ? 17'(trial - {1'b0, dvs_q}) : trial[16:0]);
			end
			default: ;
		endcase
	end

	assign push_bank = bank_q;
	assign push_row  = quo_q;
	assign push_wr   = wr_q;
	assign push_arr  = arr_q;

endmodule

// File: design/dbort_queue.sv
// ----------------------------------------------------------------------------
// DRAM bank timing access queue
// Two-entry queue between the address front end and the bank back end.
// ----------------------------------------------------------------------------
module dbort_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         full,
	output logic         empty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

// File: design/dbort_back.sv
// ----------------------------------------------------------------------------
// DRAM bank timing back end
// Looks up the bank table, computes wait and service, updates the bank
// and registers the result beat.
// ----------------------------------------------------------------------------
module dbort_back #(
	parameter int ADDR_BITS = 48,
	parameter int BANK_W    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop,
	input  logic [BANK_W-1:0]    bank,
	input  logic [ADDR_BITS-1:0] row,
	input  logic                 wr,
	input  logic [47:0]          arr,
	input  dbort_pkg::cfg_t      cfg,
	output logic                 done,
	output logic [63:0]          completion_time,
	output logic [3:0]           bank_index,
	output logic                 row_hit,
	output logic                 bank_conflict,
	output logic [63:0]          queued_cycles,
	output logic [17:0]          svc_cycles
);
	localparam int NB = 1 << BANK_W;

	logic [NB-1:0]        vld_q;
	logic [ADDR_BITS-1:0] row_q  [NB];
	logic [63:0]          free_q [NB];
	logic [63:0]          free_at;
	logic                 hit, conf;
	logic [17:0]          svc;
	logic [63:0]          start;
	logic [64:0]          sum;
	logic [63:0]          fin;

	always_comb begin
		free_at = free_q[bank];
		conf    = free_at > 64'(arr);
		start   = conf ? free_at : 64'(arr);
		hit     = vld_q[bank] && (row_q[bank] == row);
		svc     = 18'(cfg.access_lat);
		if (!hit) begin
			svc = svc + 18'(cfg.open_lat);
			if (vld_q[bank])
				svc = svc + 18'(cfg.close_lat);
		end
		if (wr)
			svc = svc + 18'(cfg.write_rec);
		sum = 65'(start) + 65'(svc);
		fin = sum[64] ? '1 : sum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
			for (int i = 0; i < NB; i++)
				free_q[i] <= '0;
		end else begin
			done <= pop;
			if (pop) begin
				vld_q[bank]  <= 1'b1;
				free_q[bank] <= fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_q[bank]     <= row;
			completion_time <= fin;
			bank_index      <= 4'(bank);
			row_hit         <= hit;
			bank_conflict   <= conf;
			queued_cycles   <= conf ? free_at - 64'(arr) : '0;
			svc_cycles      <= svc;
		end
	end

endmodule

// File: design/dram_bank_open_row_timing_top.sv
// ----------------------------------------------------------------------------
// DRAM bank open-row timing model, top level
// Start/busy command port for accesses, valid/ready configuration port.
// ----------------------------------------------------------------------------
// Usage: raise start with address, write_access and arrival_time while busy
// is low; the beat is taken at that edge. The front end divides the address
// bit-serially by the row size and then by the bank count, one quotient bit
// a cycle, then passes a two-entry queue to the back end, which looks up
// the bank table combinationally, updates it and registers the result. One
// result beat per access appears on result_valid for exactly one cycle.
// Busy stays high until the front end has pushed the access into the
// queue, so a new access is taken only after the last one has left the
// divider. In bypass mode the access goes straight to the output register
// and its result appears in the cycle after start.
// Configuration writes complete whenever cfg_valid is high (cfg_ready is
// always high); write only while no access is in flight.
// Reset clears all banks (no row open, free at zero) and loads register
// defaults. The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module dram_bank_open_row_timing_top #(
	parameter int BANK_COUNT = 16,
	parameter int ADDR_BITS  = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ADDR_BITS-1:0] address,
	input  logic                 write_access,
	input  logic [47:0]          arrival_time,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 result_valid,
	output logic [63:0]          completion_time,
	output logic [3:0]           bank_index,
	output logic                 row_hit,
	output logic                 bank_conflict,
	output logic [63:0]          queued_cycles,
	output logic [17:0]          svc_cycles
);
	localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int QW     = BANK_W + ADDR_BITS + 1 + 48;

	dbort_pkg::cfg_t cfg_q;
	logic            take, fbusy, push, pop, qfull, qempty, bdone, byp_q;
	logic [BANK_W-1:0]    pbank;
	logic [ADDR_BITS-1:0] prow;
	logic                 pwr;
	logic [47:0]          parr, byp_arr_q;
	logic [QW-1:0]        qrd;
	logic [63:0]          b_comp;
	logic [3:0]           b_bank;
	logic                 b_hit, b_conf;
	logic [63:0]          b_queued;
	logic [17:0]          b_svc;

	assign cfg_ready = 1'b1;
	assign busy      = fbusy;
	assign take      = start && !fbusy && !cfg_q.bypass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{row_size: 17'd2048, banks: 5'd8, access_lat: 16'd10,
				open_lat: 16'd10, close_lat: 16'd10, write_rec: 16'd5, bypass: 1'b0};
			byp_q <= 1'b0;
		end else begin
			byp_q <= start && !fbusy && cfg_q.bypass;
			if (cfg_valid) begin
				case (dbort_pkg::reg_idx_t'(cfg_index))
					dbort_pkg::REG_ROW_SIZE:  cfg_q.row_size   <= cfg_data[16:0];
					dbort_pkg::REG_BANKS:     cfg_q.banks      <= cfg_data[4:0];
					dbort_pkg::REG_ACCESS:    cfg_q.access_lat <= cfg_data[15:0];
					dbort_pkg::REG_OPEN:      cfg_q.open_lat   <= cfg_data[15:0];
					dbort_pkg::REG_CLOSE:     cfg_q.close_lat  <= cfg_data[15:0];
					dbort_pkg::REG_WRITE_REC: cfg_q.write_rec  <= cfg_data[15:0];
					dbort_pkg::REG_BYPASS:    cfg_q.bypass     <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !fbusy)
			byp_arr_q <= arrival_time;
	end

	dbort_front #(.ADDR_BITS(ADDR_BITS), .BANK_W(BANK_W), .BANK_COUNT(BANK_COUNT)) u_front (
		.clk, .arst_n, .take, .address, .write_access, .arrival_time,
		.cfg(cfg_q), .q_full(qfull), .busy(fbusy), .push,
		.push_bank(pbank), .push_row(prow), .push_wr(pwr), .push_arr(parr)
	);

	dbort_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .push, .wdata({pbank, prow, pwr, parr}),
		.pop, .full(qfull), .empty(qempty), .rdata(qrd)
	);

	assign pop = !qempty;

	dbort_back #(.ADDR_BITS(ADDR_BITS), .BANK_W(BANK_W)) u_back (
		.clk, .arst_n, .pop,
		.bank(qrd[QW-1 -: BANK_W]), .row(qrd[48+ADDR_BITS -: ADDR_BITS]),
		.wr(qrd[48]), .arr(qrd[47:0]), .cfg(cfg_q), .done(bdone),
		.completion_time(b_comp), .bank_index(b_bank), .row_hit(b_hit),
		.bank_conflict(b_conf), .queued_cycles(b_queued), .svc_cycles(b_svc)
	);

	assign result_valid    = bdone || byp_q;
	assign completion_time = byp_q ? 64'(byp_arr_q) : b_comp;
	assign bank_index      = byp_q ? 4'd0 : b_bank;
	assign row_hit         = !byp_q && b_hit;
	assign bank_conflict   = !byp_q && b_conf;
	assign queued_cycles   = byp_q ? 64'd0 : b_queued;
	assign svc_cycles      = byp_q ? 18'd0 : b_svc;

	assert property (@(posedge clk) disable iff (!arst_n) !(bdone && byp_q))
		else $error("bypass and bank result collide");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !qfull)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy || byp_q)
		else $error("accepted access lost");

endmodule

// File: sim/dram_bank_open_row_timing_checker.sv
// ----------------------------------------------------------------------------
// DRAM bank timing checker
// Watches the access, configuration and result channels, keeps its own copy
// of the bank table, predicts each access beat and compares result beats.
// ----------------------------------------------------------------------------
module dram_bank_open_row_timing_checker #(
	parameter int BANK_COUNT = 16,
	parameter int ADDR_BITS  = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [ADDR_BITS-1:0] address,
	input  logic                 write_access,
	input  logic [47:0]          arrival_time,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 result_valid,
	input  logic [63:0]          completion_time,
	input  logic [3:0]           bank_index,
	input  logic                 row_hit,
	input  logic                 bank_conflict,
	input  logic [63:0]          queued_cycles,
	input  logic [17:0]          svc_cycles,
	output int                   errors,
	output int                   outstanding,
	output int                   accesses,
	output int                   hits,
	output int                   conflicts
);

	typedef struct {
		logic [63:0] completion;
		logic [3:0]  bank;
		logic        hit;
		logic        conflict;
		logic [63:0] queued;
		logic [17:0] service;
	} access_timing_t;

	dbort_pkg::cfg_t cfg;
	logic            bank_open [BANK_COUNT];
	logic [63:0]     open_row  [BANK_COUNT];
	logic [63:0]     free_at   [BANK_COUNT];
	access_timing_t  expected_timings[$];

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic access_timing_t time_access(logic [63:0] addr, logic wr,
			logic [63:0] arr);
		access_timing_t r;
		logic [63:0]    rsize, nb, bank, row, begin_at, service;
		logic [64:0]    sum;
		r = '{default: '0};
		if (cfg.bypass) begin
			r.completion = arr;
			return r;
		end
		rsize = (cfg.row_size == 0) ? 64'd1 : 64'(cfg.row_size);
		nb = (cfg.banks == 0) ? 64'd1 : (cfg.banks > BANK_COUNT) ? 64'(BANK_COUNT) : 64'(cfg.banks);
		bank = (addr / rsize) % nb;
		row = addr / (rsize * nb);
		r.conflict = free_at[bank] > arr;
		r.queued = r.conflict ? free_at[bank] - arr : 64'd0;
		begin_at = r.conflict ? free_at[bank] : arr;
		r.hit = bank_open[bank] && open_row[bank] == row;
		service = 64'(cfg.access_lat);
		if (!r.hit) begin
			service += 64'(cfg.open_lat);
			if (bank_open[bank])
				service += 64'(cfg.close_lat);
		end
		if (wr)
			service += 64'(cfg.write_rec);
		sum = {1'b0, begin_at} + {1'b0, service};
		r.completion = sum[64] ? '1 : sum[63:0];
		bank_open[bank] = 1'b1;
		open_row[bank] = row;
		free_at[bank] = r.completion;
		r.bank = bank[3:0];
		r.service = service[17:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_timing_t want;
		if (!arst_n) begin
			cfg = '{row_size: 17'd2048, banks: 5'd8, access_lat: 16'd10, open_lat: 16'd10,
				close_lat: 16'd10, write_rec: 16'd5, bypass: 1'b0};
			for (int b = 0; b < BANK_COUNT; b++) begin
				bank_open[b] = 1'b0;
				open_row[b] = '0;
				free_at[b] = '0;
			end
			expected_timings.delete();
			errors = 0;
			accesses = 0;
			hits = 0;
			conflicts = 0;
		end else begin
			if (result_valid) begin
				if (expected_timings.size() == 0) begin
					report("result beat with nothing pending", completion_time, '0);
				end else begin
					want = expected_timings.pop_front();
					if (completion_time !== want.completion)
						report("completion_time", completion_time, want.completion);
					if (bank_index !== want.bank)
						report("bank_index", 64'(bank_index), 64'(want.bank));
					if (row_hit !== want.hit)
						report("row_hit", 64'(row_hit), 64'(want.hit));
					if (bank_conflict !== want.conflict)
						report("bank_conflict", 64'(bank_conflict), 64'(want.conflict));
					if (queued_cycles !== want.queued)
						report("queued_cycles", queued_cycles, want.queued);
					if (svc_cycles !== want.service)
						report("svc_cycles", 64'(svc_cycles), 64'(want.service));
				end
			end
			if (start && !busy) begin
				want = time_access(64'(address), write_access, 64'(arrival_time));
				expected_timings.push_back(want);
				accesses++;
				hits += want.hit;
				conflicts += want.conflict;
			end
			if (cfg_valid && cfg_ready) begin
				case (dbort_pkg::reg_idx_t'(cfg_index))
					dbort_pkg::REG_ROW_SIZE:  cfg.row_size = cfg_data[16:0];
					dbort_pkg::REG_BANKS:     cfg.banks = cfg_data[4:0];
					dbort_pkg::REG_ACCESS:    cfg.access_lat = cfg_data[15:0];
					dbort_pkg::REG_OPEN:      cfg.open_lat = cfg_data[15:0];
					dbort_pkg::REG_CLOSE:     cfg.close_lat = cfg_data[15:0];
					dbort_pkg::REG_WRITE_REC: cfg.write_rec = cfg_data[15:0];
					dbort_pkg::REG_BYPASS:    cfg.bypass = cfg_data[0];
					default: ;
				endcase
			end
		end
		outstanding = expected_timings.size();
	end

endmodule

// File: sim/dram_bank_open_row_timing_top_tb.sv
// ----------------------------------------------------------------------------
// DRAM bank open-row timing testbench
// Drives directed and random accesses over a series of register settings,
// with random gaps between beats; the checker predicts and compares.
// ----------------------------------------------------------------------------
module dram_bank_open_row_timing_top_tb;

	localparam int ADDR_BITS = 48;
	localparam int DRAIN = 2 * ADDR_BITS + 10;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [ADDR_BITS-1:0] address;
	logic                 write_access;
	logic [47:0]          arrival_time;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [2:0]           cfg_index;
	logic [31:0]          cfg_data;
	logic                 result_valid;
	logic [63:0]          completion_time;
	logic [3:0]           bank_index;
	logic                 row_hit;
	logic                 bank_conflict;
	logic [63:0]          queued_cycles;
	logic [17:0]          svc_cycles;
	int                   errors, outstanding, accesses, hits, conflicts;
	int                   stride;
	logic [47:0]          now, base;

	dram_bank_open_row_timing_top i_dut (.*);

	dram_bank_open_row_timing_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic write_reg(dbort_pkg::reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_access(logic [47:0] addr, logic wr, logic [47:0] arr);
		int gap;
		@(negedge clk);
		start = 1'b1;
		address = addr;
		write_access = wr;
		arrival_time = arr;
		do @(posedge clk); while (busy);
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic load_setting(int phase);
		logic [16:0] rs;
		logic [4:0]  nb;
		logic [15:0] lat [4];
		logic        byp;
		case (phase)
			0: begin
				rs = 17'd0;
				nb = 5'd0;
				lat = '{16'd0, 16'd0, 16'd0, 16'd0};
				byp = 1'b0;
			end
			1: begin
				rs = 17'h10000;
				nb = 5'd31;
				lat = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				byp = 1'b0;
			end
			2: begin
				rs = 17'd1;
				nb = 5'd16;
				lat = '{16'd3, 16'd7, 16'd11, 16'd2};
				byp = 1'b1;
			end
			default: begin
				rs = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'(1 << $urandom_range(0, 16));
				nb = 5'($urandom_range(0, 31));
				foreach (lat[k])
					lat[k] = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
				byp = ($urandom_range(0, 5) == 0);
			end
		endcase
		stride = (rs == 0) ? 1 : rs;
		write_reg(dbort_pkg::REG_ROW_SIZE, {$urandom} << 17 | 32'(rs));
		write_reg(dbort_pkg::REG_BANKS, {$urandom} << 5 | 32'(nb));
		write_reg(dbort_pkg::REG_ACCESS, {$urandom} << 16 | 32'(lat[0]));
		write_reg(dbort_pkg::REG_OPEN, {$urandom} << 16 | 32'(lat[1]));
		write_reg(dbort_pkg::REG_CLOSE, {$urandom} << 16 | 32'(lat[2]));
		write_reg(dbort_pkg::REG_WRITE_REC, {$urandom} << 16 | 32'(lat[3]));
		write_reg(dbort_pkg::REG_BYPASS, {$urandom} << 1 | 32'(byp));
		write_reg(dbort_pkg::REG_NONE, $urandom);
	endtask

	initial begin
		start = 1'b0;
		address = '0;
		write_access = 1'b0;
		arrival_time = '0;
		cfg_valid = 1'b0;
		cfg_index = dbort_pkg::REG_ROW_SIZE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_access(48'd0, 1'b0, 48'd0);
		send_access(48'd0, 1'b0, 48'd0);
		send_access(48'd100, 1'b1, 48'd100);
		send_access(48'd2048, 1'b1, 48'd5);
		send_access(48'd16384, 1'b0, 48'd6);
		send_access(48'd16384, 1'b1, 48'd1000);
		send_access('1, 1'b1, '1);
		send_access('1, 1'b0, '1);
		send_access(48'h5555_5555_5555, 1'b0, 48'hAAAA_AAAA_AAAA);
		send_access(48'hAAAA_AAAA_AAAA, 1'b1, 48'h5555_5555_5555);
		send_access(48'd0, 1'b1, '1);
		send_access(48'd14336, 1'b0, 48'd0);

		for (int phase = 0; phase < 14; phase++) begin
			settle();
			load_setting(phase);
			now = 48'($urandom_range(0, 1000));
			base = {16'($urandom), 32'($urandom)};
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 4) != 0) begin
					now += 48'($urandom_range(0, 40));
					send_access(base + 48'($urandom_range(0, 40)) * 48'(stride)
						+ 48'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), now);
				end else begin
					send_access({16'($urandom), 32'($urandom)}, 1'($urandom_range(0, 1)),
						$urandom_range(0, 1) ? {16'($urandom), 32'($urandom)} : now);
				end
			end
		end

		settle();
		$display("covered %0d accesses over 15 register settings, %0d row hits, %0d bank conflicts",
			accesses, hits, conflicts);
		if (errors == 0 && outstanding == 0)
			$display("dram_bank_open_row_timing_top_tb: done, clean");
		else
			$display("dram_bank_open_row_timing_top_tb: done, errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("dram_bank_open_row_timing_top_tb: done, errors");
		$finish;
	end

endmodule
